>>> design/iprs_pkg.sv
package iprs_pkg;

  localparam int ACC_WIDTH  = 64;
  localparam int HALF_WIDTH = 32;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_INIT,
    SQ_BOUND,
    SQ_DIV,
    SQ_CAND,
    SQ_EVAL,
    SQ_REPORT
  } seq_state_t;

  typedef enum logic [1:0] {
    EV_IDLE,
    EV_LO,
    EV_HI,
    EV_ADD
  } eval_state_t;

  typedef enum logic [1:0] {
    CAND_POS_D,
    CAND_NEG_D,
    CAND_POS_Q,
    CAND_NEG_Q
  } cand_sel_t;

  typedef struct packed {
    logic done;
    logic zero;
  } eval_status_t;

  typedef struct packed {
    logic done;
    logic exact;
  } div_status_t;

endpackage

>>> design/iprs_if.sv
interface iprs_in_if #(parameter int COEF_WIDTH = 15);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coefficient;
  logic                         last;

  modport source (output valid, output coefficient, output last, input ready);
  modport sink (input valid, input coefficient, input last, output ready);
endinterface

interface iprs_out_if #(parameter int COEF_WIDTH = 15);
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic signed [COEF_WIDTH-1:0] root;

  modport source (output valid, output found, output root, input ready);
  modport sink (input valid, input found, input root, output ready);
endinterface

>>> design/iprs_div.sv
module iprs_div
  import iprs_pkg::*;
#(
  parameter int COEF_WIDTH = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COEF_WIDTH-1:0] dividend,
  input  logic [COEF_WIDTH-1:0] divisor,
  output logic [COEF_WIDTH-1:0] quot,
  output div_status_t           status
);

  localparam int CNW = $clog2(COEF_WIDTH + 1);

  logic                  busy_r, busy_nxt;
  logic [CNW-1:0]        cnt_r, cnt_nxt;
  logic [COEF_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [COEF_WIDTH-1:0] rem_r, rem_nxt;
  logic [COEF_WIDTH-1:0] dsr_r, dsr_nxt;
  div_status_t           status_r, status_nxt;
  logic [COEF_WIDTH:0]   trial;
  logic [COEF_WIDTH:0]   diff;

  // One quotient bit per cycle by restoring division.
  always_comb begin
    trial      = {rem_r, dvd_r[COEF_WIDTH-1]};
    diff       = trial - {1'b0, dsr_r};
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    dsr_nxt    = dsr_r;
    status_nxt = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNW'(COEF_WIDTH);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[COEF_WIDTH]) begin
        rem_nxt = diff[COEF_WIDTH-1:0];
        dvd_nxt = {dvd_r[COEF_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[COEF_WIDTH-1:0];
        dvd_nxt = {dvd_r[COEF_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_nxt         = 1'b0;
        status_nxt.done  = 1'b1;
        status_nxt.exact = (rem_nxt == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      status_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quot   = dvd_r;
  assign status = status_r;

endmodule

>>> design/iprs_eval.sv
module iprs_eval
  import iprs_pkg::*;
#(
  parameter int COEF_WIDTH = 15,
  parameter int MAX_TERMS  = 9
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [COEF_WIDTH:0]             x,
  input  logic [$clog2(MAX_TERMS+1)-1:0]         terms,
  input  logic signed [COEF_WIDTH-1:0]           coef,
  output logic [(MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1)-1:0] coef_idx,
  output eval_status_t                           status
);

  localparam int XW = COEF_WIDTH + 1;
  localparam int PW = HALF_WIDTH + 1 + XW;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  eval_state_t              state_r, state_nxt;
  logic [ACC_WIDTH-1:0]     acc_r, acc_nxt;
  logic signed [XW-1:0]     x_r, x_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic [ACC_WIDTH-1:0]     plo_r, plo_nxt;
  logic [HALF_WIDTH-1:0]    phi_r, phi_nxt;
  eval_status_t             status_r, status_nxt;
  logic [HALF_WIDTH-1:0]    a_sel;
  logic signed [PW-1:0]     prod;
  logic [CW-1:0]            terms_m1;
  logic [ACC_WIDTH-1:0]     sum;

  // Horner step acc * x + c in 64-bit wrapping arithmetic, with the product
  // split over the two 32-bit halves of the accumulator on one multiplier.
  always_comb begin
    a_sel      = (state_r == EV_LO) ? acc_r[HALF_WIDTH-1:0]
                                    : acc_r[ACC_WIDTH-1:HALF_WIDTH];
    prod       = $signed({1'b0, a_sel}) * x_r;
    terms_m1   = terms - CW'(1);
    sum        = plo_r + {phi_r, {HALF_WIDTH{1'b0}}} + ACC_WIDTH'(coef);
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    idx_nxt    = idx_r;
    plo_nxt    = plo_r;
    phi_nxt    = phi_r;
    status_nxt = '0;
    case (state_r)
      EV_IDLE: begin
        if (start) begin
          acc_nxt   = '0;
          x_nxt     = x;
          idx_nxt   = terms_m1[IW-1:0];
          state_nxt = EV_LO;
        end
      end
      EV_LO: begin
        plo_nxt   = ACC_WIDTH'(prod);
        state_nxt = EV_HI;
      end
      EV_HI: begin
        phi_nxt   = prod[HALF_WIDTH-1:0];
        state_nxt = EV_ADD;
      end
      EV_ADD: begin
        acc_nxt = sum;
        if (idx_r == '0) begin
          status_nxt.done = 1'b1;
          status_nxt.zero = (sum == '0);
          state_nxt       = EV_IDLE;
        end else begin
          idx_nxt   = idx_r - IW'(1);
          state_nxt = EV_LO;
        end
      end
      default: state_nxt = EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= EV_IDLE;
      status_r <= '0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    idx_r <= idx_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
  end

  assign coef_idx = idx_r;
  assign status   = status_r;

endmodule

>>> design/integer_polynomial_root_search.sv
// Integer root search for a polynomial with integer coefficients. Coefficients
// arrive one per request, lowest power first, and up to MAX_TERMS are kept;
// later ones are dropped. A request with last set ends the polynomial: the
// block then tests each divisor d of the constant term n, from 1 while d*d
// does not exceed |n|, and for each divisor evaluates the candidates d, -d,
// n/d and -n/d in that order with exact 64-bit wrapping Horner evaluation.
// One result request follows: the first root found, or found low and a root
// of zero. After a coefficient without last the block stays idle and takes
// the next one. After last, each divisor trial runs in the bit-serial divider,
// and each candidate is evaluated on the single shared multiplier. No new
// coefficient is taken while a search runs.
module integer_polynomial_root_search
  import iprs_pkg::*;
#(
  parameter int MAX_TERMS  = 9,
  parameter int COEF_WIDTH = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  iprs_in_if.sink    in_ch,
  iprs_out_if.source out_ch
);

  localparam int XW = COEF_WIDTH + 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic signed [COEF_WIDTH-1:0] coef_store [MAX_TERMS];
  logic signed [COEF_WIDTH-1:0] coef_rd_r;

  seq_state_t              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [COEF_WIDTH-1:0] n_r, n_nxt;
  logic                    n_neg_r, n_neg_nxt;
  logic [COEF_WIDTH-1:0]   mag_r, mag_nxt;
  logic [COEF_WIDTH-1:0]   d_r, d_nxt;
  logic [COEF_WIDTH:0]     sq_r, sq_nxt;
  logic [COEF_WIDTH-1:0]   q_r, q_nxt;
  cand_sel_t               k_r, k_nxt;
  logic                    found_r, found_nxt;
  logic signed [XW-1:0]    root_r, root_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic [COEF_WIDTH-1:0]   out_root_r, out_root_nxt;

  logic                    in_accept;
  logic                    div_start;
  logic                    eval_start;
  logic [COEF_WIDTH-1:0]   div_quot;
  div_status_t             div_status;
  eval_status_t            eval_status;
  logic [IW-1:0]           eval_idx;
  logic signed [XW-1:0]    n_ext;
  logic signed [XW-1:0]    n_abs;
  logic signed [XW-1:0]    d_ext;
  logic signed [XW-1:0]    q_ext;
  logic signed [XW-1:0]    cand;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == SQ_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.found = out_found_r;
  assign out_ch.root  = out_root_r;

  always_ff @(posedge clk) begin
    if (in_accept && (count_r < CW'(MAX_TERMS))) begin
      coef_store[count_r[IW-1:0]] <= in_ch.coefficient;
    end
    coef_rd_r <= coef_store[eval_idx];
  end

  always_comb begin
    n_ext = XW'(n_r);
    n_abs = n_ext[XW-1] ? -n_ext : n_ext;
    d_ext = $signed({1'b0, d_r});
    q_ext = $signed({1'b0, q_r});
    case (k_r)
      CAND_POS_D: cand = d_ext;
      CAND_NEG_D: cand = -d_ext;
      CAND_POS_Q: cand = n_neg_r ? -q_ext : q_ext;
      CAND_NEG_Q: cand = n_neg_r ? q_ext : -q_ext;
      default:    cand = d_ext;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    n_neg_nxt     = n_neg_r;
    mag_nxt       = mag_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    q_nxt         = q_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_root_nxt  = out_root_r;
    div_start     = 1'b0;
    eval_start    = 1'b0;
    case (state_r)
      SQ_IDLE: begin
        if (in_accept) begin
          if (count_r < CW'(MAX_TERMS)) begin
            count_nxt = count_r + CW'(1);
          end
          if (count_r == '0) begin
            n_nxt = in_ch.coefficient;
          end
          if (in_ch.last) begin
            state_nxt = SQ_INIT;
          end
        end
      end
      SQ_INIT: begin
        found_nxt = 1'b0;
        root_nxt  = '0;
        n_neg_nxt = n_ext[XW-1];
        mag_nxt   = n_abs[COEF_WIDTH-1:0];
        d_nxt     = COEF_WIDTH'(1);
        sq_nxt    = (COEF_WIDTH+1)'(1);
        if ((count_r == '0) || (n_ext == '0)) begin
          state_nxt = SQ_REPORT;
        end else begin
          state_nxt = SQ_BOUND;
        end
      end
      SQ_BOUND: begin
        if (sq_r > {1'b0, mag_r}) begin
          state_nxt = SQ_REPORT;
        end else begin
          div_start = 1'b1;
          state_nxt = SQ_DIV;
        end
      end
      SQ_DIV: begin
        if (div_status.done) begin
          if (div_status.exact) begin
            q_nxt     = div_quot;
            k_nxt     = CAND_POS_D;
            state_nxt = SQ_CAND;
          end else begin
            d_nxt     = d_r + COEF_WIDTH'(1);
            sq_nxt    = sq_r + {d_r, 1'b1};
            state_nxt = SQ_BOUND;
          end
        end
      end
      SQ_CAND: begin
        eval_start = 1'b1;
        state_nxt  = SQ_EVAL;
      end
      SQ_EVAL: begin
        if (eval_status.done) begin
          if (eval_status.zero) begin
            found_nxt = 1'b1;
            root_nxt  = cand;
            state_nxt = SQ_REPORT;
          end else if (k_r == CAND_NEG_Q) begin
            d_nxt     = d_r + COEF_WIDTH'(1);
            sq_nxt    = sq_r + {d_r, 1'b1};
            state_nxt = SQ_BOUND;
          end else begin
            k_nxt     = cand_sel_t'(k_r + 2'd1);
            state_nxt = SQ_CAND;
          end
        end
      end
      SQ_REPORT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_root_nxt  = root_r[COEF_WIDTH-1:0];
          count_nxt     = '0;
          state_nxt     = SQ_IDLE;
        end
      end
      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    n_neg_r     <= n_neg_nxt;
    mag_r       <= mag_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    q_r         <= q_nxt;
    k_r         <= k_nxt;
    found_r     <= found_nxt;
    root_r      <= root_nxt;
    out_found_r <= out_found_nxt;
    out_root_r  <= out_root_nxt;
  end

  iprs_div #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r),
    .divisor  (d_r),
    .quot     (div_quot),
    .status   (div_status)
  );

  iprs_eval #(
    .COEF_WIDTH (COEF_WIDTH),
    .MAX_TERMS  (MAX_TERMS)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (eval_start),
    .x        (cand),
    .terms    (count_r),
    .coef     (coef_rd_r),
    .coef_idx (eval_idx),
    .status   (eval_status)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TERMS))
    else $error("term count exceeds the store depth");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == SQ_REPORT))
    else $error("result raised outside the report step");

  a_not_found_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.root == '0))
    else $error("nonzero root with found low");

  a_eval_done_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    eval_status.done |-> (state_r == SQ_EVAL))
    else $error("evaluation finished outside a candidate test");

endmodule
